/* rtl/wsal_pkg.sv */
// Package for the weighted sum activation layer: opcodes, register indexes,
// activation codes, control structs and the sigmoid table generator.
// No dependencies.
package wsal_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned SIG_DEPTH  = 256;
  localparam int unsigned SIG_W      = 9;
  localparam longint unsigned EXP_STEP_Q32 = 64'd4034748382;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_RELU    = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_SIGMOID = 2'd2,
    ACT_ZERO    = 2'd3
  } act_mode_e;

  typedef enum logic [1:0] {
    REG_ACT_MODE  = 2'd0,
    REG_OUT_GAIN  = 2'd1,
    REG_BIAS_EN   = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  // sequencer to datapath
  typedef struct packed {
    logic issue;      // a channel enters the pipeline this cycle if the pipeline moves
    logic out_mode;   // pipeline carries output pass (else accumulate pass)
  } seq_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic busy;       // any pipeline stage holds a channel
    logic adv;        // pipeline moves this cycle
  } dp_stat_t;

  // sigmoid entry, evaluated only at elaboration for the constant table
  function automatic logic [SIG_W-1:0] sig_entry(input int idx);
    int m;
    int n;
    int k;
    longint unsigned t;
    longint unsigned den;
    longint unsigned num;
    logic [SIG_W-1:0] q;
    m = idx - 128;
    n = (m < 0) ? -m : m;
    t = 64'h1_0000_0000;
    for (k = 0; k < 128; k++) begin
      if (k < n) begin
        t = (t * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
    end
    den = 64'h1_0000_0000 + t;
    if (m >= 0) begin
      num = (64'd256 << 32) + (den >> 1);
    end else begin
      num = t * 64'd256 + (den >> 1);
    end
    q = '0;
    for (k = SIG_W - 1; k >= 0; k--) begin
      if (num >= (den << k)) begin
        num = num - (den << k);
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

/* rtl/wsal_in_if.sv */
// Input channel of the weighted sum activation layer: valid/ready plus item fields.
// Depends on nothing.
interface wsal_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         electrode;
  logic [3:0]         channel;
  logic signed [15:0] value;
  logic               last_electrode;

  modport source (output valid, opcode, electrode, channel, value, last_electrode,
                  input ready);
  modport sink   (input valid, opcode, electrode, channel, value, last_electrode,
                  output ready);
endinterface

/* rtl/wsal_out_if.sv */
// Result channel of the weighted sum activation layer: valid/ready plus result fields.
// Depends on nothing.
interface wsal_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_channel;
  logic signed [15:0] out_value;
  logic               last_of_run;

  modport source (output valid, out_channel, out_value, last_of_run, input ready);
  modport sink   (input valid, out_channel, out_value, last_of_run, output ready);
endinterface

/* rtl/wsal_seq.sv */
// Sequencer: accepts transactions, steps the channel counter through the
// accumulate and output passes and waits for the pipeline to drain.
// Depends on wsal_pkg.
module wsal_seq import wsal_pkg::*; #(
  parameter int unsigned NUM_ELECTRODES = 16,
  parameter int unsigned NUM_CHANNELS   = 16,
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       opcode_i,
  input  logic [IDX_W-1:0] electrode_i,
  input  logic             last_electrode_i,
  output logic             in_ready_o,
  input  dp_stat_t         stat_i,
  output seq_ctl_t         ctl_o,
  output logic [CW-1:0]    ch_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last_q, last_d;
  logic          outm_q, outm_d;
  logic          el_ok;
  logic          cnt_end;

  assign el_ok   = (32'(electrode_i) < NUM_ELECTRODES);
  assign cnt_end = (cnt_q == CW'(NUM_CHANNELS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    outm_d  = outm_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && opcode_i == OP_SAMPLE) begin
          last_d = last_electrode_i;
          cnt_d  = '0;
          if (el_ok) begin
            state_d = ST_MAC;
          end else if (last_electrode_i) begin
            state_d = ST_OUT;
            outm_d  = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_OUT: begin
        if (stat_i.adv) begin
          cnt_d = cnt_q + CW'(1);
          if (cnt_end) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy) begin
          cnt_d = '0;
          if (!outm_q && last_q) begin
            state_d = ST_OUT;
            outm_d  = 1'b1;
          end else begin
            state_d = ST_IDLE;
            outm_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      outm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      outm_q  <= outm_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign ctl_o.issue    = (state_q == ST_MAC) || (state_q == ST_OUT);
  assign ctl_o.out_mode = outm_q;
  assign ch_o           = cnt_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat_i.busy)
    else $error("transaction accepted with channels in flight");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.issue |-> (32'(cnt_q) < NUM_CHANNELS))
    else $error("channel counter out of range");

  a_out_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) && (state_d == ST_OUT) |-> !outm_q && last_q && !stat_i.busy)
    else $error("output pass started before accumulate pass drained");

endmodule

/* rtl/wsal_dp.sv */
// Datapath: weight, bias and sum stores, the shared 16x16 multiplier pipeline,
// scaling, bias, activation, gain saturation and the result register.
// Depends on wsal_pkg.
module wsal_dp import wsal_pkg::*; #(
  parameter int unsigned NUM_ELECTRODES = 16,
  parameter int unsigned NUM_CHANNELS   = 16,
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned WDEPTH = NUM_ELECTRODES * NUM_CHANNELS,
  localparam int unsigned AW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_accept_i,
  input  logic [1:0]               opcode_i,
  input  logic [IDX_W-1:0]         electrode_i,
  input  logic [IDX_W-1:0]         channel_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [1:0]               act_mode_i,
  input  logic signed [DATA_W-1:0] out_gain_i,
  input  logic                     bias_en_i,
  input  seq_ctl_t                 ctl_i,
  input  logic [CW-1:0]            ch_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         out_channel_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     last_of_run_o
);

  localparam logic signed [ACC_W:0] ACC_MAX = 41'sd549755813887;
  localparam logic signed [ACC_W:0] ACC_MIN = -41'sd549755813888;

  logic signed [DATA_W-1:0] wmem [WDEPTH];
  logic signed [DATA_W-1:0] bmem [NUM_CHANNELS];
  logic signed [ACC_W-1:0]  smem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  sv_q;
  logic [SIG_W-1:0]         sig_lut [SIG_DEPTH];

  logic signed [DATA_W-1:0] val_q;
  logic [AW-1:0]            base_q;

  logic                     ch_ok, el_ok;
  logic                     wr_w, wr_b, ld_smp;
  logic                     adv, iss;

  logic                     v1_q, v2_q, v3_q;
  logic [CW-1:0]            ch1_q, ch2_q, ch3_q;
  logic signed [DATA_W-1:0] w1_q, b1_q;
  logic signed [ACC_W-1:0]  s1_q, s2_q, s3_q;
  logic signed [DATA_W-1:0] opa_q, opb_q, opa_d, opb_d;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [ACC_W-1:0]  sh_acc;
  logic signed [DATA_W-1:0] x_sc, x_b, act;
  logic signed [DATA_W:0]   x_diff;
  logic signed [DATA_W-1:0] x_q4;
  logic signed [DATA_W:0]   sig_pos;
  logic [7:0]               sig_idx;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [PROD_W-1:0] y_sh;
  logic signed [DATA_W-1:0] y_sat;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_ch_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic                     out_last_q;

  for (genvar gi = 0; gi < SIG_DEPTH; gi++) begin : g_sig
    assign sig_lut[gi] = sig_entry(gi);
  end

  assign ch_ok  = (32'(channel_i) < NUM_CHANNELS);
  assign el_ok  = (32'(electrode_i) < NUM_ELECTRODES);
  assign wr_w   = in_accept_i && (opcode_i == OP_WEIGHT) && ch_ok && el_ok;
  assign wr_b   = in_accept_i && (opcode_i == OP_BIAS) && ch_ok;
  assign ld_smp = in_accept_i && (opcode_i == OP_SAMPLE);

  assign adv = !ctl_i.out_mode || !out_valid_q || out_ready_i;
  assign iss = ctl_i.issue && adv;

  assign stat_o.busy = v1_q || v2_q || v3_q;
  assign stat_o.adv  = adv;

  always_ff @(posedge clk_i) begin
    if (ld_smp) begin
      val_q  <= value_i;
      base_q <= AW'(32'(electrode_i) * NUM_CHANNELS);
    end
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (wr_w) begin
      wmem[AW'(32'(electrode_i) * NUM_CHANNELS + 32'(channel_i))] <= value_i;
    end
    if (iss) begin
      w1_q <= wmem[base_q + AW'(ch_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      bmem[CW'(channel_i)] <= value_i;
    end
    if (iss) begin
      b1_q <= bmem[ch_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && adv && !ctl_i.out_mode) begin
      smem[ch3_q] <= acc_new;
    end
    if (iss) begin
      s1_q <= sv_q[ch_i] ? smem[ch_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      if (v3_q && adv && !ctl_i.out_mode) begin
        sv_q[ch3_q] <= 1'b1;
      end
      if (iss && ctl_i.out_mode) begin
        sv_q[ch_i] <= 1'b0;
      end
    end
  end

  // stage 1: scale, bias, activation
  always_comb begin
    sh_acc = s1_q >>> 12;
    if (sh_acc > 40'sd32767) begin
      x_sc = 16'sh7fff;
    end else if (sh_acc < -40'sd32768) begin
      x_sc = 16'sh8000;
    end else begin
      x_sc = sh_acc[DATA_W-1:0];
    end
    x_diff = {x_sc[DATA_W-1], x_sc} - {b1_q[DATA_W-1], b1_q};
    if (!bias_en_i) begin
      x_b = x_sc;
    end else if (x_diff > 17'sd32767) begin
      x_b = 16'sh7fff;
    end else if (x_diff < -17'sd32768) begin
      x_b = 16'sh8000;
    end else begin
      x_b = x_diff[DATA_W-1:0];
    end
    x_q4    = x_b >>> 4;
    sig_pos = {x_q4[DATA_W-1], x_q4} + 17'sd128;
    if (sig_pos < 17'sd0) begin
      sig_idx = 8'd0;
    end else if (sig_pos > 17'sd255) begin
      sig_idx = 8'd255;
    end else begin
      sig_idx = sig_pos[7:0];
    end
    unique case (act_mode_i)
      ACT_RELU:    act = x_b[DATA_W-1] ? '0 : x_b;
      ACT_STEP:    act = x_b[DATA_W-1] ? '0 : 16'sd256;
      ACT_SIGMOID: act = signed'({{(DATA_W - SIG_W){1'b0}}, sig_lut[sig_idx]});
      default:     act = '0;
    endcase
    opa_d = ctl_i.out_mode ? act : val_q;
    opb_d = ctl_i.out_mode ? out_gain_i : w1_q;
  end

  // stage 3: accumulate or gain saturation
  always_comb begin
    acc_sum = {s3_q[ACC_W-1], s3_q} + (ACC_W + 1)'(prod_q);
    if (acc_sum > ACC_MAX) begin
      acc_new = ACC_MAX[ACC_W-1:0];
    end else if (acc_sum < ACC_MIN) begin
      acc_new = ACC_MIN[ACC_W-1:0];
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
    y_sh = prod_q >>> 8;
    if (y_sh > 32'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_sh < -32'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= iss;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch1_q  <= ch_i;
      ch2_q  <= ch1_q;
      ch3_q  <= ch2_q;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      prod_q <= opa_q * opb_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && v3_q && ctl_i.out_mode) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q && ctl_i.out_mode) begin
      out_ch_q   <= IDX_W'(ch3_q);
      out_val_q  <= y_sat;
      out_last_q <= (ch3_q == CW'(NUM_CHANNELS - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_value_o   = out_val_q;
  assign last_of_run_o = out_last_q;

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ctl_i.out_mode) |-> (sv_q == '0))
    else $error("channel sums not cleared after output pass");

endmodule

/* rtl/weighted_sum_activation_layer_unit.sv */
// Top level of the weighted sum activation layer: APB configuration registers,
// sequencer and datapath. Depends on wsal_pkg, wsal_in_if, wsal_out_if,
// wsal_seq and wsal_dp.
//
// Usage:
//   in_i carries transactions: weight writes, bias writes and electrode samples.
//   Weight and bias writes produce nothing.
//   A sample runs one multiply-accumulate per channel through the shared
//   multiplier pipeline, then waits for the pipeline to drain.
//   A sample marked last_electrode then runs the output pass over the same
//   pipeline, one channel per cycle while out_o is not stalled, and out_o
//   carries NUM_CHANNELS results in ascending channel order, last_of_run on
//   the final one.
//   in_i.ready is high only while the sequencer is idle.
//   A stalled out_o freezes the output pass; the result register holds.
//   Reset clears the registers (mode 0, gain 1.0, bias off) and the channel
//   sums; weight and bias stores hold nothing until written.
//   Configuration: APB writes at byte address 4*index, only while idle.
module weighted_sum_activation_layer_unit import wsal_pkg::*; #(
  parameter int unsigned NUM_ELECTRODES = 16,
  parameter int unsigned NUM_CHANNELS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wsal_in_if.sink            in_i,
  wsal_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [1:0]               act_mode_q;
  logic signed [DATA_W-1:0] out_gain_q;
  logic                     bias_en_q;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;
  logic                     in_accept;
  seq_ctl_t                 ctl;
  dp_stat_t                 stat;
  logic [CW-1:0]            ch;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q <= ACT_RELU;
      out_gain_q <= 16'sd256;
      bias_en_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACT_MODE: act_mode_q <= pwdata[1:0];
        REG_OUT_GAIN: out_gain_q <= signed'(pwdata[DATA_W-1:0]);
        REG_BIAS_EN:  bias_en_q  <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACT_MODE: prdata = {30'b0, act_mode_q};
      REG_OUT_GAIN: prdata = {{(PDATA_W - DATA_W){out_gain_q[DATA_W-1]}}, out_gain_q};
      REG_BIAS_EN:  prdata = {31'b0, bias_en_q};
      default:      prdata = '0;
    endcase
  end

  assign in_accept = in_i.valid && in_i.ready;

  wsal_seq #(
    .NUM_ELECTRODES (NUM_ELECTRODES),
    .NUM_CHANNELS   (NUM_CHANNELS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .opcode_i         (in_i.opcode),
    .electrode_i      (in_i.electrode),
    .last_electrode_i (in_i.last_electrode),
    .in_ready_o       (in_i.ready),
    .stat_i           (stat),
    .ctl_o            (ctl),
    .ch_o             (ch)
  );

  wsal_dp #(
    .NUM_ELECTRODES (NUM_ELECTRODES),
    .NUM_CHANNELS   (NUM_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .opcode_i      (in_i.opcode),
    .electrode_i   (in_i.electrode),
    .channel_i     (in_i.channel),
    .value_i       (in_i.value),
    .act_mode_i    (act_mode_q),
    .out_gain_i    (out_gain_q),
    .bias_en_i     (bias_en_q),
    .ctl_i         (ctl),
    .ch_i          (ch),
    .stat_o        (stat),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_channel_o (out_o.out_channel),
    .out_value_o   (out_o.out_value),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

/* test/tb_weighted_sum_activation_layer_unit.sv */
`timescale 1ns / 100ps
// Testbench for weighted_sum_activation_layer_unit: a directed table, then random phases of
// weight/bias loads and electrode samples, every result checked against a behavioral model.
// Depends on wsal_pkg, wsal_in_if, wsal_out_if and the DUT.
module tb_weighted_sum_activation_layer_unit;
  import wsal_pkg::*;

  localparam int NUM_EL       = 16;
  localparam int NUM_CH       = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_ITEMS   = 112;
  localparam int PHASES       = 8;
  localparam longint ACC_HI   = 64'sd549755813887;
  localparam longint ACC_LO   = -64'sd549755813888;

  typedef struct packed {
    logic [3:0]  chan;
    logic [15:0] level;
    logic        tail;
  } chan_result_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_e    cfg_idx;
    logic [15:0] cfg_val;
    opcode_e     op;
    logic [3:0]  el;
    logic [3:0]  ch;
    logic [15:0] val;
    logic        last;
    bit          typed;
    logic [15:0] typed_v;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  wsal_in_if  in_ch();
  wsal_out_if out_ch();

  weighted_sum_activation_layer_unit #(
    .NUM_ELECTRODES(NUM_EL),
    .NUM_CHANNELS  (NUM_CH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // layer model state
  logic signed [15:0] weight_mem [NUM_EL][NUM_CH];
  bit                 weight_set [NUM_EL][NUM_CH];
  logic signed [15:0] bias_mem [NUM_CH];
  longint             acc_sum [NUM_CH];
  int                 sigmoid_lut [256];
  act_mode_e          act_mode = ACT_RELU;
  logic signed [15:0] gain = 16'sd256;
  logic               bias_on = 1'b0;
  chan_result_t       levels_q[$];

  plan_row_t plan_q[$];
  bit        calm = 1'b0;
  int        err_count = 0;
  int        items_sent = 0;
  int        sample_runs = 0;
  int        results_checked = 0;
  int        cfg_writes = 0;
  int        cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1, 2, 3: return 16'(int'($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void predict_layer(opcode_e op, logic [3:0] el, logic [3:0] ch,
                                        logic signed [15:0] v, logic last, bit typed,
                                        logic [15:0] typed_v);
    longint       x;
    longint       act;
    longint       y;
    int           c;
    chan_result_t r;
    case (op)
      OP_WEIGHT: begin
        weight_mem[el][ch] = v;
        weight_set[el][ch] = 1'b1;
      end
      OP_BIAS: bias_mem[ch] = v;
      OP_SAMPLE: begin
        for (c = 0; c < NUM_CH; c++) begin
          acc_sum[c] = sat(acc_sum[c] + longint'(v) * longint'(weight_mem[el][c]),
                           ACC_LO, ACC_HI);
        end
        if (last) begin
          sample_runs++;
          for (c = 0; c < NUM_CH; c++) begin
            x = sat(acc_sum[c] >>> 12, -32768, 32767);
            if (bias_on) x = sat(x - longint'(bias_mem[c]), -32768, 32767);
            case (act_mode)
              ACT_RELU:    act = (x < 0) ? 0 : x;
              ACT_STEP:    act = (x < 0) ? 0 : 256;
              ACT_SIGMOID: act = sigmoid_lut[sat((x >>> 4) + 128, 0, 255)];
              default:     act = 0;
            endcase
            y = sat((act * longint'(gain)) >>> 8, -32768, 32767);
            r.chan  = 4'(c);
            r.level = typed ? typed_v : 16'(y);
            r.tail  = (c == NUM_CH - 1);
            levels_q.push_back(r);
            acc_sum[c] = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(opcode_e op, logic [3:0] el, logic [3:0] ch, logic [15:0] v,
                           logic last, bit typed, logic [15:0] typed_v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.opcode         = op;
    in_ch.electrode      = el;
    in_ch.channel        = ch;
    in_ch.value          = v;
    in_ch.last_electrode = last;
    in_ch.valid          = 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_layer(op, el, ch, v, last, typed, typed_v);
    if (op != OP_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_row(logic [3:0] el);
    int c;
    for (c = 0; c < NUM_CH; c++) begin
      send_item(OP_WEIGHT, el, 4'(c), pick_value(), 1'($urandom), 1'b0, 16'h0);
    end
  endtask

  // idle the input, wait out pending results and the block's own tail
  task automatic settle();
    in_ch.valid = 1'b0;
    while (levels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [15:0] val);
    logic [PDATA_W-1:0] got;
    logic [PDATA_W-1:0] mask;
    settle();
    paddr  = {idx, 2'b00};
    pwdata = PDATA_W'(val);
    pwrite = 1'b1;
    psel   = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_ACT_MODE: begin
        mask     = 32'h3;
        act_mode = act_mode_e'(val[1:0]);
      end
      REG_OUT_GAIN: begin
        mask = 32'hFFFF;
        gain = val;
      end
      REG_BIAS_EN: begin
        mask    = 32'h1;
        bias_on = val[0];
      end
      default: mask = '0;
    endcase
    if ((got & mask) !== (PDATA_W'(val) & mask)) begin
      report_mismatch($sformatf("register %s reads 0x%0h, wrote 0x%0h", idx.name(), got, val));
    end
    cfg_writes++;
  endtask

  function automatic void plan_item(opcode_e op, logic [3:0] el, logic [3:0] ch,
                                    logic [15:0] v, logic last, bit typed,
                                    logic [15:0] typed_v);
    plan_row_t p;
    p.is_cfg  = 1'b0;
    p.cfg_idx = REG_UNUSED;
    p.cfg_val = '0;
    p.op      = op;
    p.el      = el;
    p.ch      = ch;
    p.val     = v;
    p.last    = last;
    p.typed   = typed;
    p.typed_v = typed_v;
    plan_q.push_back(p);
  endfunction

  function automatic void plan_cfg(reg_idx_e idx, logic [15:0] v);
    plan_row_t p;
    p.is_cfg  = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = v;
    p.op      = OP_NONE;
    p.el      = '0;
    p.ch      = '0;
    p.val     = '0;
    p.last    = 1'b0;
    p.typed   = 1'b0;
    p.typed_v = '0;
    plan_q.push_back(p);
  endfunction

  initial begin : sigmoid_lut_build
    longint unsigned t;
    longint unsigned den;
    longint unsigned num;
    int              i;
    int              m;
    int              n;
    int              k;
    for (i = 0; i < 256; i++) begin
      m = i - 128;
      n = (m < 0) ? -m : m;
      t = 64'h1_0000_0000;
      for (k = 0; k < n; k++) t = (t * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      den = 64'h1_0000_0000 + t;
      if (m >= 0) num = (64'd256 << 32) + (den >> 1);
      else        num = t * 64'd256 + (den >> 1);
      sigmoid_lut[i] = int'(num / den);
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    chan_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (levels_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d value %0d",
                                  out_ch.out_channel, out_ch.out_value));
      end else begin
        want = levels_q.pop_front();
        results_checked++;
        if (out_ch.out_channel !== want.chan)
          report_mismatch($sformatf("out_channel %0d, want %0d", out_ch.out_channel, want.chan));
        if (out_ch.out_value !== want.level)
          report_mismatch($sformatf("ch %0d out_value %0d, want %0d", want.chan,
                                    out_ch.out_value, $signed(want.level)));
        if (out_ch.last_of_run !== want.tail)
          report_mismatch($sformatf("ch %0d last_of_run %b, want %b", want.chan,
                                    out_ch.last_of_run, want.tail));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               levels_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          i;
    int          e;
    int          c;
    int          r;
    int          phase;
    int          start;
    int          rows[$];
    bit          full;
    bit          paused;
    act_mode_e   pm;
    logic [15:0] pg;
    logic        pb;

    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_SAMPLE;
    in_ch.electrode      = '0;
    in_ch.channel        = '0;
    in_ch.value          = '0;
    in_ch.last_electrode = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    paused  = 1'b0;
    for (e = 0; e < NUM_EL; e++) begin
      for (c = 0; c < NUM_CH; c++) begin
        weight_mem[e][c] = '0;
        weight_set[e][c] = 1'b0;
      end
    end
    for (c = 0; c < NUM_CH; c++) begin
      bias_mem[c] = '0;
      acc_sum[c]  = 0;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // electrode 0 is unity weight (Q4.12) so outputs read straight off the sample
    for (c = 0; c < NUM_CH; c++) send_item(OP_WEIGHT, 4'd0, 4'(c), 16'h1000, 1'b0, 1'b0, 16'h0);
    load_row(4'd1);
    for (c = 0; c < NUM_CH; c++) send_item(OP_BIAS, 4'(c), 4'(c), pick_value(), 1'b0, 1'b0, 16'h0);

    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h7FFF, 1'b1, 1'b1, 16'h7FFF);
    plan_item(OP_SAMPLE, 4'd0,  4'd15, 16'h8000, 1'b1, 1'b1, 16'h0000);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'd100,  1'b0, 1'b0, 16'h0);
    plan_item(OP_SAMPLE, 4'd1,  4'd0,  16'd50,   1'b0, 1'b0, 16'h0);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  -16'sd300, 1'b1, 1'b0, 16'h0);
    plan_item(OP_NONE,   4'd0,  4'd0,  16'd123,  1'b1, 1'b0, 16'h0);
    plan_item(OP_WEIGHT, 4'd15, 4'd15, 16'h8000, 1'b1, 1'b0, 16'h0);
    plan_item(OP_BIAS,   4'd15, 4'd15, 16'h7FFF, 1'b1, 1'b0, 16'h0);
    plan_cfg(REG_ACT_MODE, 16'(ACT_STEP));
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'hFFFF, 1'b1, 1'b1, 16'h0000);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'd256);
    plan_cfg(REG_OUT_GAIN, 16'h8000);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'd5,    1'b1, 1'b1, 16'h8000);
    plan_cfg(REG_OUT_GAIN, 16'h7FFF);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'd1,    1'b1, 1'b1, 16'h7FFF);
    plan_cfg(REG_ACT_MODE, 16'(ACT_ZERO));
    plan_item(OP_SAMPLE, 4'd1,  4'd0,  16'h7FFF, 1'b1, 1'b1, 16'h0000);
    plan_cfg(REG_ACT_MODE, 16'(ACT_SIGMOID));
    plan_cfg(REG_OUT_GAIN, 16'd256);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h7FFF, 1'b1, 1'b0, 16'h0);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h8000, 1'b1, 1'b0, 16'h0);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'd128);
    plan_cfg(REG_BIAS_EN, 16'd1);
    plan_item(OP_SAMPLE, 4'd1,  4'd0,  16'd1000, 1'b1, 1'b0, 16'h0);
    plan_item(OP_SAMPLE, 4'd0,  4'd0,  -16'sd7,  1'b1, 1'b0, 16'h0);

    for (i = 0; i < plan_q.size(); i++) begin
      if (plan_q[i].is_cfg) cfg_write(plan_q[i].cfg_idx, plan_q[i].cfg_val);
      else send_item(plan_q[i].op, plan_q[i].el, plan_q[i].ch, plan_q[i].val,
                     plan_q[i].last, plan_q[i].typed, plan_q[i].typed_v);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin pm = ACT_RELU;    pg = 16'd256;        pb = 1'b0; end
        1:       begin pm = ACT_SIGMOID; pg = 16'd256;        pb = 1'b1; end
        2:       begin pm = ACT_STEP;    pg = 16'h8000;       pb = 1'b0; end
        3:       begin pm = ACT_RELU;    pg = 16'h7FFF;       pb = 1'b1; end
        4:       begin pm = ACT_ZERO;    pg = 16'($urandom);  pb = 1'b1; end
        5:       begin pm = ACT_SIGMOID; pg = 16'($urandom);  pb = 1'b0; end
        6:       begin pm = ACT_RELU;    pg = 16'h0000;       pb = 1'b1; end
        default: begin pm = ACT_STEP;    pg = 16'($urandom);  pb = 1'b0; end
      endcase
      cfg_write(REG_ACT_MODE, 16'(pm));
      cfg_write(REG_OUT_GAIN, pg);
      cfg_write(REG_BIAS_EN, 16'(pb));
      calm  = (phase == 3);
      start = items_sent;
      while (items_sent - start < RAND_ITEMS / PHASES) begin
        if (phase == 2 && !paused && items_sent - start >= 10) begin
          settle();
          paused = 1'b1;
        end
        rows.delete();
        for (e = 0; e < NUM_EL; e++) begin
          full = 1'b1;
          for (c = 0; c < NUM_CH; c++) if (!weight_set[e][c]) full = 1'b0;
          if (full) rows.push_back(e);
        end
        r = $urandom_range(0, 99);
        if (r < 55 && rows.size() > 0) begin
          send_item(OP_SAMPLE, 4'(rows[$urandom_range(0, rows.size() - 1)]), 4'($urandom),
                    pick_value(), ($urandom_range(0, 2) == 0), 1'b0, 16'h0);
        end else if (r < 62) begin
          load_row(4'($urandom));
        end else if (r < 78) begin
          send_item(OP_WEIGHT, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom),
                    1'b0, 16'h0);
        end else if (r < 90) begin
          send_item(OP_BIAS, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom),
                    1'b0, 16'h0);
        end else begin
          send_item(OP_NONE, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom),
                    1'b0, 16'h0);
        end
      end
    end
    calm = 1'b0;

    settle();
    $display("Run covered %0d transactions, %0d output runs, %0d channel results checked,",
             items_sent, sample_runs, results_checked);
    $display("%0d register writes over all activation modes, gain extremes and bias on/off",
             cfg_writes);
    if (err_count == 0 && levels_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
